/* rtl/modbus_rtu_receive_framer_core_assert.svh */
// Assertion macros for the receive framer.
`ifndef MODBUS_RTU_RECEIVE_FRAMER_CORE_ASSERT_SVH
`define MODBUS_RTU_RECEIVE_FRAMER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition a implies b in the same cycle.
`define MRTU_ASSERT_SAME(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// Condition a implies b in the next cycle.
`define MRTU_ASSERT_NEXT(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`else

`define MRTU_ASSERT_SAME(label, clk, rstn, a, b, msg)
`define MRTU_ASSERT_NEXT(label, clk, rstn, a, b, msg)

`endif

`endif

/* rtl/mrtu_pkg.sv */
`default_nettype none

package mrtu_pkg;

    localparam logic [2:0] CMD_RX_BYTE  = 3'd0;
    localparam logic [2:0] CMD_TICK     = 3'd1;
    localparam logic [2:0] CMD_TX_BEGIN = 3'd2;
    localparam logic [2:0] CMD_READ     = 3'd3;
    localparam logic [2:0] CMD_RELEASE  = 3'd4;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS      = 8'd1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
        logic [8:0] tx_length;
    } in_t;

    typedef struct packed {
        logic [1:0] frame_status;
        logic [8:0] frame_length;
        logic [7:0] read_data;
        logic       driver_enabled;
        logic       driver_off_event;
    } out_t;

endpackage

`default_nettype wire

/* rtl/mrtu_ram.sv */
`default_nettype none

module mrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/mrtu_ctrl.sv */
`default_nettype none

module mrtu_ctrl #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [mrtu_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire logic [mrtu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                accept,
    input  wire mrtu_pkg::in_t                       item,
    output logic                                     wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]          wr_addr,
    output logic [7:0]                               wr_data,
    output logic                                     rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]          rd_addr,
    output mrtu_pkg::out_t                           res
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int WPW = $clog2(BUFFER_DEPTH + 1);

    logic [1:0]     phase_reg,    phase_next;
    logic [WPW-1:0] wp_reg,       wp_next;
    logic [15:0]    timer_reg,    timer_next;
    logic [8:0]     echo_cnt_reg, echo_cnt_next;
    logic [8:0]     echo_tgt_reg, echo_tgt_next;
    logic           driver_reg,   driver_next;
    logic           sending_reg,  sending_next;
    logic [7:0]     first_reg,    first_next;
    logic [7:0]     dev_addr_reg;
    logic [15:0]    gap_reg;
    logic           off_event;
    logic [AW+7:0]  idx_ext;
    logic [WPW+8:0] len_ext;

    assign idx_ext = {{AW{1'b0}}, item.read_index};
    assign rd_addr = idx_ext[AW-1:0];
    assign wr_data = item.rx_byte;

    always_comb begin
        phase_next    = phase_reg;
        wp_next       = wp_reg;
        timer_next    = timer_reg;
        echo_cnt_next = echo_cnt_reg;
        echo_tgt_next = echo_tgt_reg;
        driver_next   = driver_reg;
        sending_next  = sending_reg;
        first_next    = first_reg;
        off_event     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = wp_reg[AW-1:0];
        rd_en         = 1'b0;
        if (accept) begin
            unique case (item.cmd)
                mrtu_pkg::CMD_RX_BYTE: begin
                    if (driver_reg) begin
                        // count our own echo
                        echo_cnt_next = echo_cnt_reg + 9'd1;
                        if (echo_cnt_next >= echo_tgt_reg) begin
                            driver_next  = 1'b0;
                            sending_next = 1'b0;
                            phase_next   = mrtu_pkg::PH_IDLE;
                            wp_next      = '0;
                            timer_next   = '0;
                            off_event    = 1'b1;
                        end
                    end else if (!sending_reg) begin
                        if (phase_reg == mrtu_pkg::PH_IDLE) begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            first_next = item.rx_byte;
                            wp_next    = WPW'(1);
                            phase_next = mrtu_pkg::PH_COLLECT;
                            timer_next = gap_reg;
                        end else if (phase_reg == mrtu_pkg::PH_COLLECT &&
                                     wp_reg < WPW'(BUFFER_DEPTH)) begin
                            wr_en      = 1'b1;
                            wp_next    = wp_reg + WPW'(1);
                            timer_next = gap_reg;
                        end else if (phase_reg != mrtu_pkg::PH_DONE) begin
                            // overflow: drop the frame
                            phase_next = mrtu_pkg::PH_IDLE;
                            wp_next    = '0;
                            timer_next = '0;
                        end
                    end
                end
                mrtu_pkg::CMD_TICK: begin
                    if (timer_reg != 16'd0) begin
                        timer_next = timer_reg - 16'd1;
                        if (timer_reg == 16'd1) begin
                            if (first_reg != dev_addr_reg && first_reg != 8'd0) begin
                                phase_next = mrtu_pkg::PH_IDLE;
                                wp_next    = '0;
                            end else begin
                                phase_next = mrtu_pkg::PH_DONE;
                            end
                        end
                    end
                end
                mrtu_pkg::CMD_TX_BEGIN: begin
                    driver_next   = 1'b1;
                    sending_next  = 1'b1;
                    echo_tgt_next = item.tx_length;
                    echo_cnt_next = '0;
                end
                mrtu_pkg::CMD_READ: begin
                    rd_en = (32'(item.read_index) < 32'(BUFFER_DEPTH));
                end
                mrtu_pkg::CMD_RELEASE: begin
                    phase_next = mrtu_pkg::PH_IDLE;
                    wp_next    = '0;
                    timer_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign len_ext = {9'd0, wp_next};

    always_comb begin
        res                  = '0;
        res.frame_status     = phase_next;
        res.frame_length     = len_ext[8:0];
        res.driver_enabled   = driver_next;
        res.driver_off_event = off_event;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= mrtu_pkg::PH_IDLE;
            wp_reg       <= '0;
            timer_reg    <= '0;
            echo_cnt_reg <= '0;
            echo_tgt_reg <= '0;
            driver_reg   <= 1'b0;
            sending_reg  <= 1'b0;
            dev_addr_reg <= 8'd1;
            gap_reg      <= 16'd4;
        end else begin
            phase_reg    <= phase_next;
            wp_reg       <= wp_next;
            timer_reg    <= timer_next;
            echo_cnt_reg <= echo_cnt_next;
            echo_tgt_reg <= echo_tgt_next;
            driver_reg   <= driver_next;
            sending_reg  <= sending_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    mrtu_pkg::REG_DEVICE_ADDRESS: dev_addr_reg <= cfg_wdata[7:0];
                    mrtu_pkg::REG_GAP_TICKS:      gap_reg      <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // shadow of buffer entry zero for the address check at gap expiry
    always_ff @(posedge aclk) begin
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

/* rtl/modbus_rtu_receive_framer_core.sv */
// Modbus RTU receive framer with RS-485 echo suppression.
// Input channel (s_valid/s_ready/s_data) carries one command per transfer:
// received byte, timer tick, transmit begin, buffer read or frame release.
// Every accepted command yields exactly one result on m_valid/m_ready/m_data
// with the frame status, stored length, driver state and, for a buffer read,
// the stored byte.
// Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data) set the
// station address (index 0) and the gap length in ticks (index 1); they are
// always taken and are meant for idle periods.
// Throughput is one command per cycle while the output is not stalled.
// The command and its frame buffer read register at the accepting edge
// (p1 stage and RAM output); the output register then loads from them and
// drives m_valid.
// When the receiver stalls, up to two results are held (RAM stage and output
// register) before s_ready drops.
// Reset (aresetn low, synchronous) clears the framer and echo state and loads
// the register defaults; the frame buffer is not cleared and needs no sweep.
`default_nettype none

`include "modbus_rtu_receive_framer_core_assert.svh"

module modbus_rtu_receive_framer_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire mrtu_pkg::in_t                       s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output mrtu_pkg::out_t                           m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mrtu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mrtu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic           s_xfer;
    logic           load_out;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_data;
    mrtu_pkg::out_t res;

    logic           p1_valid_reg;
    logic           p1_rd_reg;
    mrtu_pkg::out_t p1_res_reg;
    mrtu_pkg::out_t p1_out;
    logic           m_valid_reg;
    mrtu_pkg::out_t m_data_reg;

    assign cfg_ready = 1'b1;
    assign load_out  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !p1_valid_reg || load_out;
    assign s_xfer    = s_valid && s_ready;

    mrtu_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_idx  (cfg_index),
        .cfg_wdata(cfg_data),
        .accept   (s_xfer),
        .item     (s_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .res      (res)
    );

    // read port only fires on a transfer, so read data holds while stalled
    mrtu_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_frame_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                p1_valid_reg <= s_xfer;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        p1_out           = p1_res_reg;
        p1_out.read_data = p1_rd_reg ? rd_data : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            p1_rd_reg  <= rd_en;
            p1_res_reg <= res;
        end
        if (load_out) begin
            m_data_reg <= p1_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MRTU_ASSERT_SAME(a_wr_on_xfer, aclk, aresetn, wr_en || rd_en, s_xfer, "RAM access without transfer")
    `MRTU_ASSERT_NEXT(a_rd_reaches_p1, aclk, aresetn, rd_en, p1_valid_reg && p1_rd_reg, "read lost")
    `MRTU_ASSERT_NEXT(a_p1_hold, aclk, aresetn, p1_valid_reg && !load_out, p1_valid_reg && $stable(rd_data), "stalled read data changed")

endmodule

`default_nettype wire
